// File: rtl/tkst_pkg.sv
// shared types and constants for the top-k sorted tracker
`default_nettype none

package tkst_pkg;

    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned SOURCE_W = 16;
    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned FORM_W   = 32;
    localparam int unsigned RANK_W   = 3;

    // one input item
    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [SOURCE_W-1:0] source_id;
        logic [HANDLE_W-1:0] handle_sample;
        logic [FORM_W-1:0]   form_sample;
        logic                final_entry;
    } entry_t;

    // one result item
    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [COUNT_W-1:0]  ranked_count;
        logic [SOURCE_W-1:0] ranked_source;
        logic [HANDLE_W-1:0] ranked_handle;
        logic [FORM_W-1:0]   ranked_form;
        logic                last_rank;
    } ranked_t;

    // contents of one slot of the list
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SOURCE_W-1:0] source;
        logic [HANDLE_W-1:0] handle;
        logic [FORM_W-1:0]   form;
    } slot_t;

    // control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/tkst_cell.sv
// one slot of the sorted list: compare, insert and shift
`default_nettype none

module tkst_cell
    import tkst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire slot_t      new_slot,
    input  wire slot_t      left_slot,
    input  wire logic       left_gt,
    input  wire slot_t      right_slot,
    output slot_t           slot,
    output logic            gt
);

    slot_t slot_reg;
    slot_t slot_next;

    // new count beats the count held here
    assign gt   = new_slot.count > slot_reg.count;
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.shift)
        begin
            slot_next = right_slot;
        end
        else if (ctrl.insert && gt)
        begin
            // boundary cell takes the new entry, the rest move down one
            slot_next = left_gt ? left_slot : new_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/top_k_sorted_tracker_core.sv
// top level of the top-k sorted tracker: chain of slot cells and readout control
`default_nettype none

// Keeps the TOP_K entries with the largest nonzero counts in descending order,
// one cell per rank. Each accepted entry is compared against every cell at once
// and inserted in parallel: cells whose count it beats take their left
// neighbor's slot, and the first of them takes the new entry, so ties keep
// the earlier entry ahead. An entry that is zero or does not beat the last
// cell changes nothing. Non-final entries are accepted one per cycle outside
// a readout. The entry marked final is inserted as usual, then the chain shifts
// toward rank 0 once per output transfer, presenting cell 0 as the result; after
// TOP_K transfers the chain holds all zeros and input transfers resume. While
// those TOP_K output transfers are pending, entry_stall is high.

module top_k_sorted_tracker_core
    import tkst_pkg::*;
#(
    parameter int unsigned TOP_K = 6
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    // input channel
    input  wire logic    entry_valid,
    output logic         entry_stall,
    input  wire entry_t  entry,
    // result channel
    output logic         rank_valid,
    input  wire logic    rank_stall,
    output ranked_t      ranked
);

    localparam int unsigned CNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [CNT_W-1:0] LAST_RANK = CNT_W'(TOP_K - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] rank_cnt_reg;
    logic [CNT_W-1:0] rank_cnt_next;

    logic       entry_xfer;
    logic       rank_xfer;
    logic       at_last;
    cell_ctrl_t ctrl;
    slot_t      new_slot;

    slot_t cell_slot [TOP_K];
    logic  cell_gt   [TOP_K];

    assign entry_xfer = entry_valid && !entry_stall;
    assign rank_xfer  = rank_valid && !rank_stall;
    assign at_last    = rank_cnt_reg == LAST_RANK;

    // incoming entry as a slot
    assign new_slot.count  = entry.entry_count;
    assign new_slot.source = entry.source_id;
    assign new_slot.handle = entry.handle_sample;
    assign new_slot.form   = entry.form_sample;

    // insert on every input transfer, shift toward rank 0 on every readout
    assign ctrl.insert = entry_xfer;
    assign ctrl.shift  = rank_xfer;

    // the chain of cells, rank 0 on the left
    for (genvar i = 0; i < TOP_K; i++)
    begin : g_cell
        slot_t left_slot;
        logic  left_gt;
        slot_t right_slot;

        if (i == 0)
        begin : g_head
            assign left_slot = new_slot;
            assign left_gt   = 1'b0;
        end
        else
        begin : g_body
            assign left_slot = cell_slot[i-1];
            assign left_gt   = cell_gt[i-1];
        end

        if (i == TOP_K - 1)
        begin : g_tail
            // zeros enter at the tail so the readout clears the list
            assign right_slot = '0;
        end
        else
        begin : g_mid
            assign right_slot = cell_slot[i+1];
        end

        tkst_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_slot   (new_slot),
            .left_slot  (left_slot),
            .left_gt    (left_gt),
            .right_slot (right_slot),
            .slot       (cell_slot[i]),
            .gt         (cell_gt[i])
        );
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        rank_cnt_next = rank_cnt_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                rank_cnt_next = '0;
                if (entry_xfer && entry.final_entry)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rank_xfer)
                begin
                    if (at_last)
                    begin
                        state_next    = ST_COLLECT;
                        rank_cnt_next = '0;
                    end
                    else
                    begin
                        rank_cnt_next = rank_cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next    = ST_COLLECT;
                rank_cnt_next = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        entry_stall = 1'b0;
        rank_valid  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                entry_stall = 1'b0;
                rank_valid  = 1'b0;
            end
            ST_EMIT:
            begin
                entry_stall = 1'b1;
                rank_valid  = 1'b1;
            end
            default:
            begin
                entry_stall = 1'b1;
                rank_valid  = 1'b0;
            end
        endcase
    end

    // result slot comes straight from cell 0, rank from the counter, stable while stalled
    assign ranked.rank          = RANK_W'(rank_cnt_reg);
    assign ranked.ranked_count  = cell_slot[0].count;
    assign ranked.ranked_source = cell_slot[0].source;
    assign ranked.ranked_handle = cell_slot[0].handle;
    assign ranked.ranked_form   = cell_slot[0].form;
    assign ranked.last_rank     = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            rank_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rank_cnt_reg <= rank_cnt_next;
        end
    end

    // a final entry transfer starts the readout
    a_final_starts_readout: assert property (
        @(posedge clk) disable iff (!rst_n)
        (entry_xfer && entry.final_entry) |=> rank_valid
    ) else $error("readout did not start after final entry");

    // the last rank transfer ends the readout and leaves the list cleared
    a_last_rank_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rank_xfer && ranked.last_rank) |=> (!rank_valid && cell_slot[0].count == '0)
    ) else $error("list not cleared after last rank");

    // the chain stays in descending order of count
    for (genvar j = 0; j + 1 < TOP_K; j++)
    begin : g_order_chk
        a_sorted: assert property (
            @(posedge clk) disable iff (!rst_n)
            cell_slot[j].count >= cell_slot[j+1].count
        ) else $error("cell chain out of order");
    end

endmodule

`default_nettype wire
